### rtl/core/int8_mlp_inference_unit_defines.svh
// Assertion macros shared by the int8 MLP inference unit.
// Standalone header, no dependencies; include by bare file name.
`ifndef INT8_MLP_INFERENCE_UNIT_DEFINES_SVH
`define INT8_MLP_INFERENCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/i8mlp_pkg.sv
// Package for the int8 MLP inference unit: sequencer state, microcode
// control word types and the microcode program. No dependencies.
`timescale 1ns / 1ps

package i8mlp_pkg;

  // request kinds carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  localparam int PC_W = 4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // parameter memory read address source
  typedef enum logic [2:0] {
    PA_NONE,
    PA_B1_I,
    PA_W1_I,
    PA_B2_I,
    PA_W2_PTR,
    PA_BO,
    PA_WO_J
  } addr_sel_t;

  // datapath operation, executed in the cycle after issue
  typedef enum logic [2:0] {
    DP_NOP,
    DP_BIAS,
    DP_MAC_X,
    DP_MAC_H1,
    DP_MAC_H2,
    DP_WB_H1,
    DP_WB_H2,
    DP_OUT
  } dp_op_t;

  // counter advance: next = jump taken ? count + 1 : 0
  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_I,
    CNT_J,
    CNT_JW
  } cnt_sel_t;

  // jump condition: taken while the counter is not at its last value
  typedef enum logic [2:0] {
    JC_NONE,
    JC_I1,
    JC_I2,
    JC_J1,
    JC_J2,
    JC_END
  } jump_cond_t;

  typedef struct packed {
    addr_sel_t          addr_sel;
    dp_op_t             dp_op;
    cnt_sel_t           cnt_sel;
    jump_cond_t         cond;
    logic [PC_W-1:0]    target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_FIRST = 4'd0;
  localparam logic [PC_W-1:0] PC_LAST  = 4'd8;

  // microcode program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{PA_NONE, DP_NOP, CNT_NONE, JC_END, PC_FIRST};
    unique case (pc)
      // layer 1: bias, one product, write back, per neuron
      4'd0: w = '{PA_B1_I,   DP_BIAS,   CNT_NONE, JC_NONE, 4'd0};
      4'd1: w = '{PA_W1_I,   DP_MAC_X,  CNT_NONE, JC_NONE, 4'd0};
      4'd2: w = '{PA_NONE,   DP_WB_H1,  CNT_I,    JC_I1,   4'd0};
      // layer 2: bias, HIDDEN_ONE products, write back, per neuron
      4'd3: w = '{PA_B2_I,   DP_BIAS,   CNT_NONE, JC_NONE, 4'd0};
      4'd4: w = '{PA_W2_PTR, DP_MAC_H1, CNT_JW,   JC_J1,   4'd4};
      4'd5: w = '{PA_NONE,   DP_WB_H2,  CNT_I,    JC_I2,   4'd3};
      // output neuron
      4'd6: w = '{PA_BO,     DP_BIAS,   CNT_NONE, JC_NONE, 4'd0};
      4'd7: w = '{PA_WO_J,   DP_MAC_H2, CNT_J,    JC_J2,   4'd7};
      4'd8: w = '{PA_NONE,   DP_OUT,    CNT_NONE, JC_END,  4'd0};
      default: w = '{PA_NONE, DP_NOP, CNT_NONE, JC_END, PC_FIRST};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/int8_mlp_inference_unit.sv
// int8 MLP inference unit: parameter memory, microcoded sequencer and a
// single shared multiply-accumulate. Depends on i8mlp_pkg and the defines header.
`timescale 1ns / 1ps
`include "int8_mlp_inference_unit_defines.svh"

// A write request (tuser = 0) stores one signed byte in the parameter memory
// and gives no result. A run request (tuser = 1) pushes x_in through two
// ReLU layers and one saturating output neuron and gives one result (y_out,
// led_level). One 8x8 multiply-accumulate does all work, driven by a
// nine-step microcode program and forming one product per cycle; after a run
// request is taken the input is held off until the last step has been
// issued, so a new request is taken only once the previous run's program is
// through. The result is registered and becomes valid after the last step
// has executed. The last step waits as long as an earlier result is still
// untaken. A finished result waits in the output register while the next
// request is taken. Memory layout: layer-1 weights, layer-1 biases, layer-2
// weights (row per layer-2 neuron), layer-2 biases, output weights, output
// bias. Writes at or beyond the end are dropped.
module int8_mlp_inference_unit #(
  parameter int HIDDEN_ONE = 16,
  parameter int HIDDEN_TWO = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: param_addr, param_value, x_in, zero padding (lowest bit first)
  input  logic [((($clog2(2*HIDDEN_ONE + HIDDEN_ONE*HIDDEN_TWO + 2*HIDDEN_TWO + 1)
                 + 16) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: func
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: y_out, led_level (lowest bit first)
  output logic [15:0] m_axis_tdata
);

  // memory map
  localparam int OFS_W1 = 0;
  localparam int OFS_B1 = OFS_W1 + HIDDEN_ONE;
  localparam int OFS_W2 = OFS_B1 + HIDDEN_ONE;
  localparam int OFS_B2 = OFS_W2 + HIDDEN_TWO * HIDDEN_ONE;
  localparam int OFS_WO = OFS_B2 + HIDDEN_TWO;
  localparam int OFS_BO = OFS_WO + HIDDEN_TWO;
  localparam int PARAM_DEPTH = OFS_BO + 1;
  localparam int PADDR_W = $clog2(PARAM_DEPTH);

  localparam int HMAX   = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
  localparam int CNT_W  = (HMAX > 1) ? $clog2(HMAX) : 1;
  localparam int IDX1_W = (HIDDEN_ONE > 1) ? $clog2(HIDDEN_ONE) : 1;
  localparam int IDX2_W = (HIDDEN_TWO > 1) ? $clog2(HIDDEN_TWO) : 1;
  localparam int W2P_W  = (HIDDEN_ONE * HIDDEN_TWO > 1) ?
                          $clog2(HIDDEN_ONE * HIDDEN_TWO) : 1;
  localparam int ACC_W  = 18 + $clog2(HMAX + 1);
  localparam int Q_W    = ACC_W - 4;

  localparam logic [CNT_W-1:0] I1_LAST = CNT_W'(HIDDEN_ONE - 1);
  localparam logic [CNT_W-1:0] I2_LAST = CNT_W'(HIDDEN_TWO - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(127);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-128);

  // request fields
  logic [PADDR_W-1:0] param_addr;
  logic signed [7:0]  param_value;
  logic signed [7:0]  x_in;
  logic               in_accept;

  assign param_addr  = s_axis_tdata[PADDR_W-1:0];
  assign param_value = s_axis_tdata[PADDR_W+7:PADDR_W];
  assign x_in        = s_axis_tdata[PADDR_W+15:PADDR_W+8];
  assign in_accept   = s_axis_tvalid && s_axis_tready;

  // sequencer state
  i8mlp_pkg::seq_state_t state, state_next;
  logic [i8mlp_pkg::PC_W-1:0] pc, pc_next;
  logic [CNT_W-1:0] cnt_i, cnt_i_next;
  logic [CNT_W-1:0] cnt_j, cnt_j_next;
  logic [W2P_W-1:0] w2_ptr, w2_ptr_next;
  i8mlp_pkg::ucode_t cw;
  logic issue_en;
  logic stall;
  logic go;
  logic taken;
  logic run_start;

  // delayed datapath control
  i8mlp_pkg::dp_op_t dp_op;
  logic [CNT_W-1:0]  wb_idx;

  // memories
  logic signed [7:0] param_mem [PARAM_DEPTH];
  logic [7:0]        h1_mem [HIDDEN_ONE];
  logic [7:0]        h2_mem [HIDDEN_TWO];
  logic [PADDR_W-1:0] prm_raddr;
  logic signed [7:0]  prm_rdata;
  logic [7:0]         h1_rdata;
  logic [7:0]         h2_rdata;

  // datapath
  logic signed [7:0]       x_reg;
  logic signed [ACC_W-1:0] acc, acc_next;
  logic signed [7:0]       mac_opnd;
  logic signed [15:0]      prod;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [Q_W-1:0]   quot;
  logic [7:0]              relu_val;
  logic signed [7:0]       y_sat;
  logic [7:0]              y_biased;
  logic [7:0]              led_val;
  logic signed [7:0]       y_out;
  logic [7:0]              led_level;

  assign run_start = in_accept && (s_axis_tuser == i8mlp_pkg::FUNC_RUN);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      i8mlp_pkg::ST_IDLE: begin
        if (run_start) state_next = i8mlp_pkg::ST_RUN;
      end
      i8mlp_pkg::ST_RUN: begin
        if (go && cw.cond == i8mlp_pkg::JC_END) state_next = i8mlp_pkg::ST_IDLE;
      end
      default: state_next = i8mlp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue_en      = 1'b0;
    unique case (state)
      i8mlp_pkg::ST_IDLE: s_axis_tready = 1'b1;
      i8mlp_pkg::ST_RUN:  issue_en = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        issue_en      = 1'b0;
      end
    endcase
  end

  // microcode fetch, stall on a busy output register, jump decision
  always_comb begin
    cw    = i8mlp_pkg::ucode_rom(pc);
    stall = (cw.dp_op == i8mlp_pkg::DP_OUT) && m_axis_tvalid && !m_axis_tready;
    go    = issue_en && !stall;
    unique case (cw.cond)
      i8mlp_pkg::JC_I1: taken = (cnt_i != I1_LAST);
      i8mlp_pkg::JC_I2: taken = (cnt_i != I2_LAST);
      i8mlp_pkg::JC_J1: taken = (cnt_j != I1_LAST);
      i8mlp_pkg::JC_J2: taken = (cnt_j != I2_LAST);
      default:          taken = 1'b0;
    endcase
  end

  // program counter and loop counters
  always_comb begin
    pc_next     = pc;
    cnt_i_next  = cnt_i;
    cnt_j_next  = cnt_j;
    w2_ptr_next = w2_ptr;
    if (run_start) begin
      pc_next     = i8mlp_pkg::PC_FIRST;
      cnt_i_next  = '0;
      cnt_j_next  = '0;
      w2_ptr_next = '0;
    end else if (go) begin
      pc_next = taken ? cw.target : pc + 1'b1;
      case (cw.cnt_sel)
        i8mlp_pkg::CNT_I:  cnt_i_next = taken ? cnt_i + 1'b1 : '0;
        i8mlp_pkg::CNT_J:  cnt_j_next = taken ? cnt_j + 1'b1 : '0;
        i8mlp_pkg::CNT_JW: begin
          cnt_j_next  = taken ? cnt_j + 1'b1 : '0;
          w2_ptr_next = w2_ptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // parameter read address
  always_comb begin
    case (cw.addr_sel)
      i8mlp_pkg::PA_B1_I:   prm_raddr = PADDR_W'(OFS_B1) + PADDR_W'(cnt_i);
      i8mlp_pkg::PA_W1_I:   prm_raddr = PADDR_W'(OFS_W1) + PADDR_W'(cnt_i);
      i8mlp_pkg::PA_B2_I:   prm_raddr = PADDR_W'(OFS_B2) + PADDR_W'(cnt_i);
      i8mlp_pkg::PA_W2_PTR: prm_raddr = PADDR_W'(OFS_W2) + PADDR_W'(w2_ptr);
      i8mlp_pkg::PA_BO:     prm_raddr = PADDR_W'(OFS_BO);
      i8mlp_pkg::PA_WO_J:   prm_raddr = PADDR_W'(OFS_WO) + PADDR_W'(cnt_j);
      default:              prm_raddr = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= i8mlp_pkg::ST_IDLE;
      pc            <= i8mlp_pkg::PC_FIRST;
      cnt_i         <= '0;
      cnt_j         <= '0;
      w2_ptr        <= '0;
      dp_op         <= i8mlp_pkg::DP_NOP;
      m_axis_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      cnt_i  <= cnt_i_next;
      cnt_j  <= cnt_j_next;
      w2_ptr <= w2_ptr_next;
      dp_op  <= go ? cw.dp_op : i8mlp_pkg::DP_NOP;
      if (dp_op == i8mlp_pkg::DP_OUT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)         m_axis_tvalid <= 1'b0;
    end
  end

  // parameter memory: write on a write request, registered read
  always_ff @(posedge clk) begin
    if (in_accept && (s_axis_tuser == i8mlp_pkg::FUNC_WRITE) &&
        ({1'b0, param_addr} < (PADDR_W + 1)'(PARAM_DEPTH))) begin
      param_mem[param_addr] <= param_value;
    end
    prm_rdata <= param_mem[prm_raddr];
  end

  // activation memories, written at the delayed neuron index, read at cnt_j
  always_ff @(posedge clk) begin
    if (dp_op == i8mlp_pkg::DP_WB_H1) h1_mem[wb_idx[IDX1_W-1:0]] <= relu_val;
    if (dp_op == i8mlp_pkg::DP_WB_H2) h2_mem[wb_idx[IDX2_W-1:0]] <= relu_val;
    h1_rdata <= h1_mem[cnt_j[IDX1_W-1:0]];
    h2_rdata <= h2_mem[cnt_j[IDX2_W-1:0]];
  end

  // multiply-accumulate
  always_comb begin
    case (dp_op)
      i8mlp_pkg::DP_MAC_H1: mac_opnd = h1_rdata;
      i8mlp_pkg::DP_MAC_H2: mac_opnd = h2_rdata;
      default:              mac_opnd = x_reg;
    endcase
    prod = prm_rdata * mac_opnd;
    case (dp_op) inside
      i8mlp_pkg::DP_BIAS:   acc_next = {{(ACC_W-12){prm_rdata[7]}}, prm_rdata, 4'b0000};
      i8mlp_pkg::DP_MAC_X,
      i8mlp_pkg::DP_MAC_H1,
      i8mlp_pkg::DP_MAC_H2: acc_next = acc + {{(ACC_W-16){prod[15]}}, prod};
      default:              acc_next = acc;
    endcase
  end

  // divide by 16 toward zero, then ReLU clamp or saturate
  always_comb begin
    acc_adj = acc + {{(ACC_W-4){1'b0}}, {4{acc[ACC_W-1]}}};
    quot    = acc_adj[ACC_W-1:4];
    if (quot < 0)          relu_val = 8'd0;
    else if (quot > Q_MAX) relu_val = 8'd127;
    else                   relu_val = quot[7:0];
    if (quot > Q_MAX)      y_sat = 8'sd127;
    else if (quot < Q_MIN) y_sat = -8'sd128;
    else                   y_sat = quot[7:0];
    // (y+128)*255/256 is y+128-1, floored at zero
    y_biased = {~y_sat[7], y_sat[6:0]};
    led_val  = (y_biased == 8'd0) ? 8'd0 : y_biased - 8'd1;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (run_start) x_reg <= x_in;
    acc    <= acc_next;
    wb_idx <= cnt_i;
    if (dp_op == i8mlp_pkg::DP_OUT) begin
      y_out     <= y_sat;
      led_level <= led_val;
    end
  end

  assign m_axis_tdata = {led_level, y_out};

  // checks
  `CHK_NEXT(a_run_starts, clk, rst, run_start,
            (state == i8mlp_pkg::ST_RUN) && (pc == i8mlp_pkg::PC_FIRST),
            "run request did not start the program")
  `CHK_IMPLY(a_out_slot_free, clk, rst, dp_op == i8mlp_pkg::DP_OUT, !m_axis_tvalid,
             "result written over an untaken result")
  `CHK_IMPLY(a_pc_in_program, clk, rst, state == i8mlp_pkg::ST_RUN,
             pc <= i8mlp_pkg::PC_LAST, "program counter beyond program end")
  `CHK_IMPLY(a_idle_no_dp, clk, rst,
             (state == i8mlp_pkg::ST_IDLE) && $past(state == i8mlp_pkg::ST_IDLE),
             dp_op == i8mlp_pkg::DP_NOP, "datapath active while sequencer idle")

endmodule

### verif/testbench.sv
// Testbench for int8_mlp_inference_unit: parameter loads, directed and random inference requests.
// Needs only i8mlp_pkg and the RTL; predicts or looks up every result, compares field by field.
`timescale 1ns / 1ps

module testbench;

  // network shape and parameter memory map
  localparam int H1 = 16;
  localparam int H2 = 16;
  localparam int W1_BASE = 0;
  localparam int B1_BASE = W1_BASE + H1;
  localparam int W2_BASE = B1_BASE + H1;
  localparam int B2_BASE = W2_BASE + H1 * H2;
  localparam int WO_BASE = B2_BASE + H2;
  localparam int BO_ADDR = WO_BASE + H2;
  localparam int PARAM_DEPTH = BO_ADDR + 1;

  localparam int RUN_LATENCY = 400;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int MIXED_ITEMS = 530;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] led;
  } infer_result_t;

  typedef struct {
    logic          func;
    logic [8:0]    addr;
    logic [7:0]    value;
    logic [7:0]    x;
    bit            typed;
    infer_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = i8mlp_pkg::FUNC_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // predictor state and scoreboard
  logic signed [7:0] param_store [PARAM_DEPTH];
  infer_result_t     pending_results [$];
  stim_row_t         dir_rows [$];
  int                n_writes = 0;
  int                n_runs = 0;
  int                n_checked = 0;
  int                n_errors = 0;
  int                cycles = 0;
  bit                sender_burst = 1'b0;
  bit                receiver_burst = 1'b0;

  int8_mlp_inference_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // param_addr, param_value, x_in, zero padding
    .s_axis_tuser  (s_tuser),   // func
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)    // y_out, led_level
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_relu(input int s);
    if (s > 127) return 127;
    if (s < 0) return 0;
    return s;
  endfunction

  // full forward pass over the current parameter store
  function automatic infer_result_t predict_inference(input logic [7:0] x);
    int            h1 [H1];
    int            h2 [H2];
    int            acc;
    int            xs;
    int            y;
    int            led;
    infer_result_t r;
    xs = int'($signed(x));
    for (int i = 0; i < H1; i++) begin
      acc = int'(param_store[B1_BASE + i]) * 16 + int'(param_store[W1_BASE + i]) * xs;
      h1[i] = clamp_relu(acc / 16);
    end
    for (int i = 0; i < H2; i++) begin
      acc = int'(param_store[B2_BASE + i]) * 16;
      for (int j = 0; j < H1; j++)
        acc += int'(param_store[W2_BASE + i * H1 + j]) * h1[j];
      h2[i] = clamp_relu(acc / 16);
    end
    acc = int'(param_store[BO_ADDR]) * 16;
    for (int i = 0; i < H2; i++)
      acc += int'(param_store[WO_BASE + i]) * h2[i];
    y = acc / 16;
    if (y > 127) y = 127;
    if (y < -128) y = -128;
    led = ((y + 128) * 255) / 256;
    r.y = y[7:0];
    r.led = led[7:0];
    return r;
  endfunction

  function automatic stim_row_t make_row(input logic func, input int addr, input int value,
                                         input int x, input bit typed, input int y,
                                         input int led);
    stim_row_t row;
    row.func = func;
    row.addr = addr[8:0];
    row.value = value[7:0];
    row.x = x[7:0];
    row.typed = typed;
    row.res.y = y[7:0];
    row.res.led = led[7:0];
    return row;
  endfunction

  // offer one request and wait for it to be taken; tvalid stays high across back-to-back requests
  task automatic send_request(input logic func, input logic [8:0] addr, input logic [7:0] value,
                              input logic [7:0] x, input bit typed, input infer_result_t res);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {7'd0, x, value, addr};
    do @(posedge clk); while (!s_tready);
    if (func == i8mlp_pkg::FUNC_WRITE) begin
      n_writes++;
      if (addr < PARAM_DEPTH) param_store[addr] = value;
    end else begin
      n_runs++;
      pending_results.push_back(typed ? res : predict_inference(x));
    end
  endtask

  task automatic send_write(input int addr, input int value);
    send_request(i8mlp_pkg::FUNC_WRITE, addr[8:0], value[7:0], 8'($urandom), 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: y_out %0d led_level %0d",
               $signed(m_tdata[7:0]), m_tdata[15:8]);
        n_errors++;
      end else begin
        infer_result_t exp_res;
        exp_res = pending_results.pop_front();
        n_checked++;
        if (m_tdata[7:0] !== exp_res.y) begin
          $error("y_out mismatch: expected %0d, actual %0d", $signed(exp_res.y),
                 $signed(m_tdata[7:0]));
          n_errors++;
        end
        if (m_tdata[15:8] !== exp_res.led) begin
          $error("led_level mismatch: expected %0d, actual %0d", exp_res.led, m_tdata[15:8]);
          n_errors++;
        end
      end
    end
  end

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = receiver_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      taken++;
    end
  end

  // request side
  initial begin
    int choice;
    int v;
    bit small_vals;
    stim_row_t row;
    small_vals = 1'b1;
    for (int a = 0; a < PARAM_DEPTH; a++) param_store[a] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // load every parameter with zero so no run reads an unwritten entry
    sender_burst = 1'b1;
    for (int a = 0; a < PARAM_DEPTH; a++) send_write(a, 0);
    sender_burst = 1'b0;

    // directed rows; ignored fields carry junk
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 511, 'hA5, 0, 1'b1, 0, 127));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 0, 'h5A, 127, 1'b1, 0, 127));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 320, 'hFF, -128, 1'b1, 0, 127));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, BO_ADDR, 127, 'h3C, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 170, 'h00, 5, 1'b1, 127, 254));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, BO_ADDR, -128, 'hC3, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 341, 'h80, -1, 1'b1, -128, 0));
    // out-of-range writes are dropped
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, PARAM_DEPTH, 5, 'hFF, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, 511, 127, 'h80, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 85, 'h7F, 0, 1'b1, -128, 0));
    // a sum of -1 divides to 0, not -1
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, BO_ADDR, 0, 'h00, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, B2_BASE, 1, 'h01, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, WO_BASE, -1, 'hFE, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 0, 'h00, 3, 1'b1, 0, 127));
    // extreme weights through one path, then the far corners of the map
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, W1_BASE, 127, 'h55, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, B1_BASE, 127, 'hAA, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, W2_BASE, 127, 'h0F, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, WO_BASE, 127, 'hF0, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 256, 'h11, 127, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 255, 'hEE, -128, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, W1_BASE, -128, 'h00, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, B2_BASE + H2 - 1, 127, 'h7E, 1'b0,
                                0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_WRITE, WO_BASE + H2 - 1, -128, 'h81, 1'b0,
                                0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 1, 'h33, -128, 1'b0, 0, 0));
    dir_rows.push_back(make_row(i8mlp_pkg::FUNC_RUN, 2, 'hCC, -77, 1'b0, 0, 0));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.func, row.addr, row.value, row.x, row.typed, row.res);
    end
    s_tvalid <= 1'b0;
    wait_drained();

    // reload with small values so outputs land away from the rails
    for (int a = 0; a < PARAM_DEPTH; a++) begin
      v = int'($urandom_range(0, 24)) - 12;
      send_write(a, v);
    end

    // mixed writes and runs
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      if (n % 100 == 0) begin
        sender_burst = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
        small_vals = ($urandom_range(0, 2) != 0);
      end
      if (n == MIXED_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      choice = $urandom_range(0, 99);
      if (choice < 40) begin
        send_request(i8mlp_pkg::FUNC_RUN, 9'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                     '0);
      end else begin
        v = small_vals ? int'($urandom_range(0, 32)) - 16 : int'($urandom_range(0, 255));
        if (choice < 48) send_write($urandom_range(PARAM_DEPTH, 511), v);
        else send_write($urandom_range(0, PARAM_DEPTH - 1), v);
      end
    end
    s_tvalid <= 1'b0;

    // drain, then let any trailing write settle
    wait_drained();
    repeat (RUN_LATENCY) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
    end
    $display("covered %0d parameter writes (in and out of range) and %0d inferences,",
             n_writes, n_runs);
    $display("%0d results checked, %0d mismatches, in %0d cycles", n_checked, n_errors, cycles);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### int8_mlp_inference_unit.f
+incdir+rtl/core
rtl/core/i8mlp_pkg.sv
rtl/core/int8_mlp_inference_unit.sv
verif/testbench.sv
